@@ rtl/bgcd_pkg.sv @@
// bgcd_pkg: shared widths, state codes and a helper function for the binary GCD block.
// No dependencies; compile first.
package bgcd_pkg;

  // Width of the payload fields on both channels
  localparam int IO_WIDTH = 64;

  // Default working width of the datapath
  localparam int DATA_WIDTH_DEF = 64;

  // Largest right shift taken in one cycle, and the width of a shift amount
  localparam int STEP_BITS = 4;
  localparam int STEP_W    = 3;

  // Sequencer state codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_STRIP = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;

  // Trailing zeros in the low nibble; an all-zero nibble counts as a full step
  function automatic logic [STEP_W-1:0] tz_step(input logic [STEP_BITS-1:0] v);
    logic [STEP_W-1:0] n;
    n = STEP_W'(STEP_BITS);
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = STEP_W'(i);
      end
    end
    return n;
  endfunction

endpackage

@@ rtl/bgcd_in_if.sv @@
// bgcd_in_if: operand channel, valid/ready with two signed operands.
// Depends on bgcd_pkg.
interface bgcd_in_if import bgcd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [IO_WIDTH-1:0] first_operand;
  logic signed [IO_WIDTH-1:0] second_operand;

  modport source (output valid, output first_operand, output second_operand, input ready);
  modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

@@ rtl/bgcd_out_if.sv @@
// bgcd_out_if: result channel, valid/ready with the unsigned divisor.
// Depends on bgcd_pkg.
interface bgcd_out_if import bgcd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [IO_WIDTH-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface

@@ rtl/binary_gcd_64.sv @@
// binary_gcd_64: greatest common divisor of two signed operands, Stein's binary method.
// Depends on bgcd_pkg, bgcd_in_if and bgcd_out_if.
//
//   channel | dir | handshake         | payload
//   in_ch   | in  | valid / ready     | first_operand, second_operand (64b signed)
//   out_ch  | out | valid / ready     | divisor (64b unsigned)
//
// One operand pair at a time. A transfer is loaded while idle, then a strip
// phase drops common factors of two in steps of up to four bits, then the
// subtract-and-shift loop does one subtraction or one right shift of up to four
// bits per step on the shared subtract/compare unit. in_ch.ready is high only
// while idle; a finished result waits in the output register while the next
// operand pair is taken, and the sequencer stalls at the finish of an item, in
// the strip phase or the loop, while the previous result is still unread.
// Synchronous reset clears the sequencer and the result valid; the data
// registers are not reset.
module binary_gcd_64 import bgcd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bgcd_in_if.sink      in_ch,
  bgcd_out_if.source   out_ch
);

  localparam int SH_W = $clog2(DATA_WIDTH);

  logic [1:0]            state_r, state_nxt;
  logic [DATA_WIDTH-1:0] a_r, a_nxt;
  logic [DATA_WIDTH-1:0] b_r, b_nxt;
  logic [SH_W-1:0]       shared_r, shared_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [IO_WIDTH-1:0]   divisor_r, divisor_nxt;

  logic [DATA_WIDTH-1:0] raw_a, raw_b, mag_a, mag_b;
  logic [STEP_W-1:0]     tz_a, tz_b, tz_ab;
  logic [DATA_WIDTH-1:0] diff_ab;
  logic [DATA_WIDTH:0]   diff_ba;
  logic [DATA_WIDTH-1:0] g_shifted;
  logic                  out_free;

  // Take magnitudes of the low DATA_WIDTH bits
  assign raw_a = in_ch.first_operand[DATA_WIDTH-1:0];
  assign raw_b = in_ch.second_operand[DATA_WIDTH-1:0];
  assign mag_a = raw_a[DATA_WIDTH-1] ? (~raw_a + DATA_WIDTH'(1)) : raw_a;
  assign mag_b = raw_b[DATA_WIDTH-1] ? (~raw_b + DATA_WIDTH'(1)) : raw_b;

  // Shared subtract/compare unit
  assign diff_ab = a_r - b_r;
  assign diff_ba = {1'b0, b_r} - {1'b0, a_r};

  // Short trailing-zero counts for the shift steps
  assign tz_a  = tz_step(a_r[STEP_BITS-1:0]);
  assign tz_b  = tz_step(b_r[STEP_BITS-1:0]);
  assign tz_ab = tz_step(a_r[STEP_BITS-1:0] | b_r[STEP_BITS-1:0]);

  // Restore the shared power of two
  assign g_shifted = a_r << shared_r;

  assign out_free = !out_valid_r || out_ch.ready;

  // Sequencer and datapath next state
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    shared_nxt    = shared_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    divisor_nxt   = divisor_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          a_nxt      = mag_a;
          b_nxt      = mag_b;
          shared_nxt = '0;
          state_nxt  = ST_STRIP;
        end
      end
      ST_STRIP: begin
        if (a_r == '0 || b_r == '0) begin
          // One operand zero: pass the other magnitude
          if (out_free) begin
            out_valid_nxt = 1'b1;
            divisor_nxt   = IO_WIDTH'(a_r | b_r);
            state_nxt     = ST_IDLE;
          end
        end else if (!a_r[0] && !b_r[0]) begin
          // Drop common factors of two
          a_nxt      = a_r >> tz_ab;
          b_nxt      = b_r >> tz_ab;
          shared_nxt = shared_r + SH_W'(tz_ab);
        end else begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!a_r[0]) begin
          a_nxt = a_r >> tz_a;
        end else if (b_r == '0) begin
          // Loop finished: a holds the odd part of the divisor
          if (out_free) begin
            out_valid_nxt = 1'b1;
            divisor_nxt   = IO_WIDTH'(g_shifted);
            state_nxt     = ST_IDLE;
          end
        end else if (!b_r[0]) begin
          b_nxt = b_r >> tz_b;
        end else if (diff_ba[DATA_WIDTH]) begin
          a_nxt = diff_ab;
        end else begin
          b_nxt = diff_ba[DATA_WIDTH-1:0];
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    shared_r  <= shared_nxt;
    divisor_r <= divisor_nxt;
  end

  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.divisor = divisor_r;

`ifndef SYNTH
  // The loop never sees a zero first value
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (a_r != '0))
    else $error("a_r is zero inside the subtract loop");

  // After stripping, at least one value is odd
  a_run_one_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (a_r[0] || b_r[0]))
    else $error("both values even inside the subtract loop");

  // A result appears only when the sequencer finishes an item
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_STRIP || $past(state_r) == ST_RUN))
    else $error("result raised without a finished item");

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(divisor_r))
    else $error("pending result overwritten");
`endif

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for binary_gcd_64, directed table then random operand pairs.
// Depends on bgcd_pkg, bgcd_in_if, bgcd_out_if and binary_gcd_64 from rtl.
module tb;
  import bgcd_pkg::*;

  typedef logic [IO_WIDTH-1:0] word_t;

  typedef struct {
    word_t first;
    word_t second;
    bit    typed;
    word_t divisor;
  } stim_row_t;

  typedef enum {ALWAYS_READY, COIN_FLIP, DUTY_PATTERN, RARE_STALL} stall_mode_t;

  localparam word_t MOST_NEG     = {1'b1, {(IO_WIDTH-1){1'b0}}};
  localparam word_t MOST_POS     = {1'b0, {(IO_WIDTH-1){1'b1}}};
  localparam int    RANDOM_ITEMS = 1330;
  localparam int    DRAIN_POINT  = 700;
  localparam int    LONG_HOLD    = 600;
  localparam int    HOLD_AT      = 300;
  localparam int    TAIL_CYCLES  = 200;
  localparam int    IDLE_LIMIT   = 4000;

  logic clk;
  logic rst_n;

  bgcd_in_if  in_ch ();
  bgcd_out_if out_ch ();

  binary_gcd_64 #(.DATA_WIDTH(IO_WIDTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  word_t     pending_divisors[$];
  stim_row_t directed_rows[$];
  int        mismatches   = 0;
  int        results_seen = 0;
  int        burst_left   = 0;
  int        idle_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Trailing zeros, capped at the top bit; zero counts as none
  function automatic int trailing_zero_count(word_t v);
    int n;
    n = 0;
    if (v == '0) return 0;
    while (!v[0] && n < IO_WIDTH - 1) begin
      v = v >> 1;
      n++;
    end
    return n;
  endfunction

  // Stein's method on the magnitudes of two two's complement operands
  function automatic word_t stein_gcd(word_t x, word_t y);
    word_t a, b;
    int    za, zb, shared;
    a = x[IO_WIDTH-1] ? -x : x;
    b = y[IO_WIDTH-1] ? -y : y;
    if (a == '0 || b == '0) return a | b;
    za = trailing_zero_count(a);
    zb = trailing_zero_count(b);
    shared = (za < zb) ? za : zb;
    a = a >> za;
    b = b >> zb;
    while (a != '0 && b != '0) begin
      if (a > b) begin
        a = a - b;
        a = a >> trailing_zero_count(a);
      end else begin
        b = b - a;
        b = b >> trailing_zero_count(b);
      end
    end
    return (a + b) << shared;
  endfunction

  function automatic word_t random_word();
    return {$urandom, $urandom};
  endfunction

  function automatic word_t corner_word();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return MOST_NEG;
      2:       return MOST_POS;
      3:       return word_t'(1);
      4:       return word_t'(1) << $urandom_range(0, IO_WIDTH - 1);
      default: return '1;
    endcase
  endfunction

  // Mix plain random pairs with shared factors, power-of-two factors, corners, small values and multiples
  task automatic random_pair(output word_t a, output word_t b);
    word_t common;
    word_t t;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        a = random_word();
        b = random_word();
      end
      4, 5: begin
        common = random_word() >> $urandom_range(1, IO_WIDTH - 1);
        a = common * (random_word() >> $urandom_range(32, IO_WIDTH - 1));
        b = common * (random_word() >> $urandom_range(32, IO_WIDTH - 1));
      end
      6: begin
        a = random_word() << $urandom_range(0, IO_WIDTH - 1);
        b = random_word() << $urandom_range(0, IO_WIDTH - 1);
      end
      7: begin
        a = corner_word();
        b = $urandom_range(0, 1) ? corner_word() : random_word();
      end
      8: begin
        a = word_t'($urandom_range(0, 1000));
        b = word_t'($urandom_range(0, 1000));
      end
      default: begin
        a = random_word() >> $urandom_range(0, 8);
        b = $urandom_range(0, 1) ? a : a * word_t'($urandom_range(1, 9));
      end
    endcase
    if ($urandom_range(0, 1)) a = -a;
    if ($urandom_range(0, 1)) b = -b;
    if ($urandom_range(0, 1)) begin
      t = a;
      a = b;
      b = t;
    end
  endtask

  // Offer one pair, hold until the transfer, then drain the block, take a gap or go straight on
  task automatic offer_pair(word_t a, word_t b, bit typed, word_t typed_div, bit drain);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.first_operand  <= a;
    in_ch.second_operand <= b;
    do @(posedge clk); while (!in_ch.ready);
    pending_divisors.push_back(typed ? typed_div : stein_gcd(a, b));
    if (drain) begin
      in_ch.valid <= 1'b0;
      while (pending_divisors.size() != 0) @(posedge clk);
    end else if (burst_left == 0) begin
      burst_left = $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Stimulus: reset, directed table, random pairs, then settle and report
  initial begin
    word_t a, b;
    in_ch.valid          <= 1'b0;
    in_ch.first_operand  <= '0;
    in_ch.second_operand <= '0;
    rst_n                <= 1'b0;

    directed_rows.push_back('{word_t'(0), word_t'(0), 1'b1, word_t'(0)});
    directed_rows.push_back('{word_t'(0), word_t'(5), 1'b1, word_t'(5)});
    directed_rows.push_back('{-word_t'(7), word_t'(0), 1'b1, word_t'(7)});
    directed_rows.push_back('{MOST_NEG, word_t'(0), 1'b1, MOST_NEG});
    directed_rows.push_back('{word_t'(0), MOST_NEG, 1'b1, MOST_NEG});
    directed_rows.push_back('{MOST_NEG, MOST_NEG, 1'b1, MOST_NEG});
    directed_rows.push_back('{MOST_POS, MOST_POS, 1'b1, MOST_POS});
    directed_rows.push_back('{MOST_POS, -MOST_POS, 1'b1, MOST_POS});
    directed_rows.push_back('{'1, '1, 1'b1, word_t'(1)});
    directed_rows.push_back('{'1, word_t'(0), 1'b1, word_t'(1)});
    directed_rows.push_back('{word_t'(1), MOST_NEG, 1'b1, word_t'(1)});
    directed_rows.push_back('{MOST_POS, MOST_NEG, 1'b1, word_t'(1)});
    directed_rows.push_back('{MOST_NEG, word_t'(6), 1'b1, word_t'(2)});
    directed_rows.push_back('{word_t'(12), -word_t'(18), 1'b1, word_t'(6)});
    directed_rows.push_back('{word_t'(48), -word_t'(180), 1'b1, word_t'(12)});
    directed_rows.push_back('{word_t'(1) << 40, word_t'(1) << 40, 1'b1, word_t'(1) << 40});
    directed_rows.push_back('{word_t'(1) << 62, word_t'(3) << 40, 1'b0, '0});
    directed_rows.push_back('{word_t'(3) << 60, -(word_t'(5) << 58), 1'b0, '0});
    directed_rows.push_back('{MOST_POS, word_t'(3), 1'b0, '0});
    // large coprime operands: a long subtract-and-shift run
    directed_rows.push_back('{word_t'(64'd7540113804746346429),
                              word_t'(64'd4660046610375530309), 1'b0, '0});
    directed_rows.push_back('{-word_t'(64'd7540113804746346429),
                              MOST_NEG + word_t'(1), 1'b0, '0});
    directed_rows.push_back('{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, '0});

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      offer_pair(directed_rows[i].first, directed_rows[i].second, directed_rows[i].typed,
                 directed_rows[i].divisor, i == directed_rows.size() - 1);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      random_pair(a, b);
      offer_pair(a, b, 1'b0, '0, n == DRAIN_POINT || n == RANDOM_ITEMS - 1);
    end

    // catch any stray result after the last one
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Receiver: rotate stall modes, with one long hold-off to back the block up
  initial begin
    stall_mode_t mode;
    int          phase;
    bit          long_hold_done;
    mode           = ALWAYS_READY;
    phase          = 0;
    long_hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!long_hold_done && results_seen >= HOLD_AT) begin
        long_hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else begin
        phase++;
        if (phase % 200 == 0) mode = stall_mode_t'($urandom_range(0, 3));
        case (mode)
          ALWAYS_READY: out_ch.ready <= 1'b1;
          COIN_FLIP:    out_ch.ready <= 1'($urandom_range(0, 1));
          DUTY_PATTERN: out_ch.ready <= (phase % 7) < 4;
          RARE_STALL:   out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Check each result transfer against the oldest pending divisor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_divisors.size() == 0) begin
        $error("divisor: expected none, got %h", out_ch.divisor);
        mismatches++;
      end else if (out_ch.divisor !== pending_divisors[0]) begin
        $error("divisor: expected %h, got %h", pending_divisors[0], out_ch.divisor);
        mismatches++;
        void'(pending_divisors.pop_front());
      end else begin
        void'(pending_divisors.pop_front());
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

endmodule

@@ binary_gcd_64.f @@
rtl/bgcd_pkg.sv
rtl/bgcd_in_if.sv
rtl/bgcd_out_if.sv
rtl/binary_gcd_64.sv
test/tb.sv
